/* hw/rtl/imusd_pkg.sv */
// Shared constants, types and codes of the IMU stillness detector.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package imusd_pkg;

   localparam int CHANNELS    = 7;
   localparam int SAMPLE_W    = 16;
   localparam int WINDOW_LOG2 = 8;
   localparam int WINDOW      = 1 << WINDOW_LOG2;
   localparam int SUM_W       = SAMPLE_W + WINDOW_LOG2;
   localparam int ROW_W       = CHANNELS * SAMPLE_W;

   localparam int CH_ACCEL_X     = 0;
   localparam int CH_ACCEL_Z     = 2;
   localparam int CH_TEMPERATURE = 3;
   localparam int CH_GYRO_X      = 4;
   localparam int CH_GYRO_Z      = 6;

   // Division by five through a reciprocal: exact for magnitudes below 2**18.
   localparam int DIV5_SHIFT = 20;
   localparam int DIV5_MUL   = ((1 << DIV5_SHIFT) + 4) / 5;
   localparam int MAG_W      = SAMPLE_W + 2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEL_LIMIT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GYRO_LIMIT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STILL_NEEDED = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOTION_RESET = 2'd3;

   localparam int STILL_W  = 10;
   localparam int MOTION_W = 4;

   localparam logic [15:0]         RST_ACCEL_LIMIT  = 16'd400;
   localparam logic [15:0]         RST_GYRO_LIMIT   = 16'd100;
   localparam logic [STILL_W-1:0]  RST_STILL_NEEDED = 10'd1000;
   localparam logic [MOTION_W-1:0] RST_MOTION_RESET = 4'd10;

   typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] sample_set_type;
   typedef logic [CHANNELS-1:0][SUM_W-1:0]    sum_set_type;
   typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] dev_set_type;

   typedef struct packed {
      logic [15:0]         accel_limit;
      logic [15:0]         gyro_limit;
      logic [STILL_W-1:0]  still_needed;
      logic [MOTION_W-1:0] motion_reset_count;
   } cfg_type;

   typedef struct packed {
      logic load_dev;
      logic load_out;
   } pipe_ctl_type;

endpackage

`default_nettype wire

/* hw/rtl/imusd_hist_mem.sv */
// Sample history ring: one row of all channels per slot, with the slot counter.
// The row for the next slot is prefetched; depends on imusd_pkg.
`default_nettype none

module imusd_hist_mem import imusd_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           wr_en,
   input  wire sample_set_type wr_row,
   output sample_set_type      old_row
);

   logic [ROW_W-1:0]       mem [WINDOW];
   logic [WINDOW-1:0]      row_valid_ff;
   logic [WINDOW_LOG2-1:0] slot_ff;
   logic [WINDOW_LOG2-1:0] slot_in;
   logic [WINDOW_LOG2-1:0] rd_addr;
   logic [ROW_W-1:0]       rd_row_ff;
   logic                   rd_valid_ff;

   assign slot_in = slot_ff + 1'b1;
   assign rd_addr = wr_en ? slot_in : slot_ff;
   assign old_row = rd_valid_ff ? sample_set_type'(rd_row_ff) : '0;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[slot_ff] <= ROW_W'(wr_row);
      end
      rd_row_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         rd_valid_ff <= row_valid_ff[rd_addr];
         if (wr_en) begin
            slot_ff               <= slot_in;
            row_valid_ff[slot_ff] <= 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/imusd_filter_bank.sv */
// Per-channel window sums and first-order filters, updated once per beat.
// Depends on imusd_pkg.
`default_nettype none

module imusd_filter_bank import imusd_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           load,
   input  wire sample_set_type sample,
   input  wire sample_set_type old_row,
   output sum_set_type         sum,
   output sample_set_type      filt
);

   sum_set_type    sum_ff;
   sum_set_type    sum_in;
   sample_set_type filt_ff;
   sample_set_type filt_in;

   assign sum  = sum_ff;
   assign filt = filt_ff;

   always_comb begin
      logic signed [MAG_W:0]     acc;
      logic [MAG_W-1:0]          mag;
      logic [2*MAG_W-1:0]        prod;
      logic [SAMPLE_W-1:0]       quot;
      logic signed [SUM_W-1:0]   x_ext;
      logic signed [SUM_W-1:0]   o_ext;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         x_ext = SUM_W'($signed(sample[ch]));
         o_ext = SUM_W'($signed(old_row[ch]));
         sum_in[ch] = sum_ff[ch] + x_ext - o_ext;
         acc  = {sample[ch][SAMPLE_W-1], sample[ch], 2'b00}
              + {{3{filt_ff[ch][SAMPLE_W-1]}}, filt_ff[ch]};
         mag  = acc[MAG_W] ? MAG_W'(-acc) : MAG_W'(acc);
         prod = mag * MAG_W'(DIV5_MUL);
         quot = prod[DIV5_SHIFT +: SAMPLE_W];
         filt_in[ch] = acc[MAG_W] ? SAMPLE_W'(-quot) : quot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         filt_ff <= '0;
      end else if (load) begin
         sum_ff  <= sum_in;
         filt_ff <= filt_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/imusd_decision.sv */
// Deviation stage, stillness counters and the result register.
// Depends on imusd_pkg.
`default_nettype none

module imusd_decision import imusd_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire pipe_ctl_type   ctl,
   input  wire cfg_type        cfg,
   input  wire sum_set_type    sum,
   input  wire sample_set_type filt,
   output logic                is_still,
   output dev_set_type         dev
);

   dev_set_type         dev_in;
   dev_set_type         dev_ff;
   logic                quiet_in;
   logic                quiet_ff;
   dev_set_type         out_dev_ff;
   logic                out_still_ff;
   logic                out_still_in;
   logic [STILL_W-1:0]  still_count_ff;
   logic [STILL_W-1:0]  still_count_in;
   logic [MOTION_W-1:0] motion_count_ff;
   logic [MOTION_W-1:0] motion_count_in;

   assign is_still = out_still_ff;
   assign dev      = out_dev_ff;

   always_comb begin
      logic [SUM_W-1:0]    adj;
      logic [SAMPLE_W-1:0] mean;
      logic [SAMPLE_W:0]   diff;
      quiet_in = 1'b1;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         adj  = sum[ch] + (sum[ch][SUM_W-1] ? SUM_W'(WINDOW - 1) : SUM_W'(0));
         mean = adj[SUM_W-1:WINDOW_LOG2];
         diff = {filt[ch][SAMPLE_W-1], filt[ch]} - {mean[SAMPLE_W-1], mean};
         dev_in[ch] = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
      end
      for (int ch = CH_ACCEL_X; ch <= CH_ACCEL_Z; ch++) begin
         if (dev_in[ch] >= cfg.accel_limit) begin
            quiet_in = 1'b0;
         end
      end
      for (int ch = CH_GYRO_X; ch <= CH_GYRO_Z; ch++) begin
         if (dev_in[ch] >= cfg.gyro_limit) begin
            quiet_in = 1'b0;
         end
      end
   end

   always_comb begin
      logic [STILL_W:0]  still_next;
      logic [MOTION_W:0] motion_next;
      still_next      = {1'b0, still_count_ff};
      motion_next     = {1'b0, motion_count_ff} + 1'b1;
      motion_count_in = motion_count_ff;
      if (quiet_ff) begin
         still_next = still_next + 1'b1;
      end else begin
         if (motion_next >= {1'b0, cfg.motion_reset_count}) begin
            motion_count_in = '0;
            still_next      = '0;
         end else begin
            motion_count_in = motion_next[MOTION_W-1:0];
         end
      end
      if (still_next >= {1'b0, cfg.still_needed}) begin
         still_count_in = cfg.still_needed;
         out_still_in   = 1'b1;
      end else begin
         still_count_in = still_next[STILL_W-1:0];
         out_still_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_dev) begin
         dev_ff   <= dev_in;
         quiet_ff <= quiet_in;
      end
      if (ctl.load_out) begin
         out_dev_ff   <= dev_ff;
         out_still_ff <= out_still_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         still_count_ff  <= '0;
         motion_count_ff <= '0;
      end else if (ctl.load_out) begin
         still_count_ff  <= still_count_in;
         motion_count_ff <= motion_count_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/imu_still_detector.sv */
// Top level of the IMU stillness detector: ports, settings and pipeline control.
// Depends on imusd_pkg, imusd_hist_mem, imusd_filter_bank and imusd_decision.
//
// A request beat carries one sample set of seven channels (three accelerometer
// axes, temperature, three gyroscope axes). Each request beat yields exactly
// one response beat with the stillness flag and the seven deviations.
// The block takes one beat per cycle while req_stall is low. The history ring row
// for the next slot is prefetched from the single-port-read memory, so its read
// latency stays off the sample path. The three stages hand on independently, so
// requests are still taken while a finished response waits; only when every stage
// is full and rsp_stall is high does req_stall rise. A stalled response holds its
// payload. Reset clears the sums, filters, counters and the valid bit of every
// history row, so the ring reads as zero with no clearing pass, and loads the
// default settings. req_stall is high during reset. Settings must be written
// through the csr_ port only while the block is idle, which the block does not
// enforce; they take effect on the next beat.
`default_nettype none

module imu_still_detector import imusd_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_wr_data,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic signed [15:0]      req_accel_x,
   input  wire logic signed [15:0]      req_accel_y,
   input  wire logic signed [15:0]      req_accel_z,
   input  wire logic signed [15:0]      req_temperature,
   input  wire logic signed [15:0]      req_gyro_x,
   input  wire logic signed [15:0]      req_gyro_y,
   input  wire logic signed [15:0]      req_gyro_z,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic                         rsp_is_still,
   output logic [15:0]                  rsp_dev_accel_x,
   output logic [15:0]                  rsp_dev_accel_y,
   output logic [15:0]                  rsp_dev_accel_z,
   output logic [15:0]                  rsp_dev_temperature,
   output logic [15:0]                  rsp_dev_gyro_x,
   output logic [15:0]                  rsp_dev_gyro_y,
   output logic [15:0]                  rsp_dev_gyro_z
);

   cfg_type        cfg_ff;
   logic           s1_valid_ff;
   logic           s2_valid_ff;
   logic           out_valid_ff;
   logic           out_ready;
   logic           s2_ready;
   logic           s1_ready;
   logic           accept;
   pipe_ctl_type   ctl;
   sample_set_type sample;
   sample_set_type old_row;
   sum_set_type    sum;
   sample_set_type filt;
   dev_set_type    dev;

   assign out_ready    = !out_valid_ff || !rsp_stall;
   assign s2_ready     = !s2_valid_ff || out_ready;
   assign s1_ready     = !s1_valid_ff || s2_ready;
   assign ctl.load_out = s2_valid_ff && out_ready;
   assign ctl.load_dev = s1_valid_ff && s2_ready;
   assign req_stall    = reset || !s1_ready;
   assign accept       = req_valid && !req_stall;
   assign rsp_valid    = out_valid_ff;

   assign sample[CH_ACCEL_X]     = req_accel_x;
   assign sample[CH_ACCEL_X + 1] = req_accel_y;
   assign sample[CH_ACCEL_Z]     = req_accel_z;
   assign sample[CH_TEMPERATURE] = req_temperature;
   assign sample[CH_GYRO_X]      = req_gyro_x;
   assign sample[CH_GYRO_X + 1]  = req_gyro_y;
   assign sample[CH_GYRO_Z]      = req_gyro_z;

   assign rsp_dev_accel_x     = dev[CH_ACCEL_X];
   assign rsp_dev_accel_y     = dev[CH_ACCEL_X + 1];
   assign rsp_dev_accel_z     = dev[CH_ACCEL_Z];
   assign rsp_dev_temperature = dev[CH_TEMPERATURE];
   assign rsp_dev_gyro_x      = dev[CH_GYRO_X];
   assign rsp_dev_gyro_y      = dev[CH_GYRO_X + 1];
   assign rsp_dev_gyro_z      = dev[CH_GYRO_Z];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.accel_limit        <= RST_ACCEL_LIMIT;
         cfg_ff.gyro_limit         <= RST_GYRO_LIMIT;
         cfg_ff.still_needed       <= RST_STILL_NEEDED;
         cfg_ff.motion_reset_count <= RST_MOTION_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ACCEL_LIMIT: begin
               cfg_ff.accel_limit <= csr_wr_data;
            end
            CSR_GYRO_LIMIT: begin
               cfg_ff.gyro_limit <= csr_wr_data;
            end
            CSR_STILL_NEEDED: begin
               cfg_ff.still_needed <= csr_wr_data[STILL_W-1:0];
            end
            CSR_MOTION_RESET: begin
               cfg_ff.motion_reset_count <= csr_wr_data[MOTION_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (ctl.load_dev) begin
            s1_valid_ff <= 1'b0;
         end
         if (ctl.load_dev) begin
            s2_valid_ff <= 1'b1;
         end else if (ctl.load_out) begin
            s2_valid_ff <= 1'b0;
         end
         if (ctl.load_out) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   imusd_hist_mem u_hist_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept),
      .wr_row  (sample),
      .old_row (old_row)
   );

   imusd_filter_bank u_filter_bank (
      .clock   (clock),
      .reset   (reset),
      .load    (accept),
      .sample  (sample),
      .old_row (old_row),
      .sum     (sum),
      .filt    (filt)
   );

   imusd_decision u_decision (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .cfg      (cfg_ff),
      .sum      (sum),
      .filt     (filt),
      .is_still (rsp_is_still),
      .dev      (dev)
   );

endmodule

`default_nettype wire

/* dv/tb_imu_still_detector.sv */
`timescale 1ns / 1ps
// Self-checking testbench for imu_still_detector: random and directed sample beats,
// predicted deviations and stillness flag compared beat by beat. Depends on imusd_pkg.

module tb_imu_still_detector import imusd_pkg::*;;

   typedef struct packed {
      logic        still;
      dev_set_type dev;
   } still_report_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic signed [15:0]     req_accel_x = '0;
   logic signed [15:0]     req_accel_y = '0;
   logic signed [15:0]     req_accel_z = '0;
   logic signed [15:0]     req_temperature = '0;
   logic signed [15:0]     req_gyro_x = '0;
   logic signed [15:0]     req_gyro_y = '0;
   logic signed [15:0]     req_gyro_z = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_is_still;
   logic [15:0]            rsp_dev_accel_x;
   logic [15:0]            rsp_dev_accel_y;
   logic [15:0]            rsp_dev_accel_z;
   logic [15:0]            rsp_dev_temperature;
   logic [15:0]            rsp_dev_gyro_x;
   logic [15:0]            rsp_dev_gyro_y;
   logic [15:0]            rsp_dev_gyro_z;

   imu_still_detector i_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_accel_x         (req_accel_x),
      .req_accel_y         (req_accel_y),
      .req_accel_z         (req_accel_z),
      .req_temperature     (req_temperature),
      .req_gyro_x          (req_gyro_x),
      .req_gyro_y          (req_gyro_y),
      .req_gyro_z          (req_gyro_z),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_is_still        (rsp_is_still),
      .rsp_dev_accel_x     (rsp_dev_accel_x),
      .rsp_dev_accel_y     (rsp_dev_accel_y),
      .rsp_dev_accel_z     (rsp_dev_accel_z),
      .rsp_dev_temperature (rsp_dev_temperature),
      .rsp_dev_gyro_x      (rsp_dev_gyro_x),
      .rsp_dev_gyro_y      (rsp_dev_gyro_y),
      .rsp_dev_gyro_z      (rsp_dev_gyro_z)
   );

   always #5 clock = ~clock;

   // Predictor state.
   int                  ring_hist [CHANNELS][WINDOW];
   int                  ring_sum [CHANNELS];
   int                  smooth [CHANNELS];
   int                  ring_pos;
   int                  still_run;
   int                  motion_run;
   logic [15:0]         lim_accel;
   logic [15:0]         lim_gyro;
   logic [STILL_W-1:0]  need_still;
   logic [MOTION_W-1:0] motion_clear_at;

   still_report_type pending_reports [$];
   sample_set_type   sample_backlog [$];
   int               samples_queued = 0;
   int               samples_accepted = 0;
   logic             sample_taken = 1'b0;
   int               mismatches = 0;
   int               send_gap = 0;
   int               stall_left = 0;
   int               hold_requests = 0;
   int               hold_served = 0;
   logic             idle_off = 1'b0;
   int               base_level [CHANNELS];
   int               accel_span;
   int               gyro_span;
   string            chan_name [CHANNELS] = '{"dev_accel_x", "dev_accel_y", "dev_accel_z",
      "dev_temperature", "dev_gyro_x", "dev_gyro_y", "dev_gyro_z"};

   function automatic void reset_predictor();
      for (int ch = 0; ch < CHANNELS; ch++) begin
         for (int k = 0; k < WINDOW; k++) ring_hist[ch][k] = 0;
         ring_sum[ch] = 0;
         smooth[ch] = 0;
      end
      ring_pos = 0;
      still_run = 0;
      motion_run = 0;
      lim_accel = RST_ACCEL_LIMIT;
      lim_gyro = RST_GYRO_LIMIT;
      need_still = RST_STILL_NEEDED;
      motion_clear_at = RST_MOTION_RESET;
   endfunction

   function automatic void apply_setting(input logic [CSR_INDEX_W-1:0] idx,
                                         input logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_ACCEL_LIMIT: begin
            lim_accel = val;
         end
         CSR_GYRO_LIMIT: begin
            lim_gyro = val;
         end
         CSR_STILL_NEEDED: begin
            need_still = val[STILL_W-1:0];
         end
         CSR_MOTION_RESET: begin
            motion_clear_at = val[MOTION_W-1:0];
         end
         default: begin
         end
      endcase
   endfunction

   function automatic still_report_type predict_stillness(input sample_set_type s);
      still_report_type r;
      int               x;
      int               mean;
      int               diff;
      logic             quiet;
      quiet = 1'b1;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         x = int'($signed(s[ch]));
         ring_sum[ch] += x - ring_hist[ch][ring_pos];
         ring_hist[ch][ring_pos] = x;
         smooth[ch] = (16 * x + 4 * smooth[ch]) / 20;
         mean = ring_sum[ch] / WINDOW;
         diff = smooth[ch] - mean;
         if (diff < 0) diff = -diff;
         r.dev[ch] = diff[15:0];
         if (ch <= CH_ACCEL_Z && r.dev[ch] >= lim_accel) quiet = 1'b0;
         if (ch >= CH_GYRO_X && r.dev[ch] >= lim_gyro) quiet = 1'b0;
      end
      ring_pos = (ring_pos + 1) % WINDOW;
      if (quiet) begin
         still_run++;
      end else begin
         motion_run++;
         if (motion_run >= motion_clear_at) begin
            motion_run = 0;
            still_run = 0;
         end
      end
      r.still = (still_run >= need_still);
      if (r.still) still_run = need_still;
      return r;
   endfunction

   function automatic void note_mismatch(input string what, input int want, input int got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
   endfunction

   function automatic void check_report(input still_report_type got);
      still_report_type want;
      if (pending_reports.size() == 0) begin
         note_mismatch("unexpected response beat", 0, 1);
         return;
      end
      want = pending_reports.pop_front();
      if (got.still !== want.still) note_mismatch("is_still", want.still, got.still);
      for (int ch = 0; ch < CHANNELS; ch++)
         if (got.dev[ch] !== want.dev[ch]) note_mismatch(chan_name[ch], want.dev[ch], got.dev[ch]);
   endfunction

   // Monitor: settings, accepted request beats and accepted response beats.
   always @(posedge clock) begin
      sample_taken <= !reset && req_valid && !req_stall;
      if (reset) begin
         reset_predictor();
      end else begin
         if (rsp_valid && !rsp_stall)
            check_report({rsp_is_still, rsp_dev_gyro_z, rsp_dev_gyro_y, rsp_dev_gyro_x,
                          rsp_dev_temperature, rsp_dev_accel_z, rsp_dev_accel_y,
                          rsp_dev_accel_x});
         if (csr_wr_en) apply_setting(csr_index, csr_wr_data);
         if (req_valid && !req_stall) begin
            pending_reports.push_back(predict_stillness({req_gyro_z, req_gyro_y, req_gyro_x,
               req_temperature, req_accel_z, req_accel_y, req_accel_x}));
            samples_accepted <= samples_accepted + 1;
         end
      end
   end

   // Driver.
   always @(negedge clock) begin
      sample_set_type s;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || sample_taken) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (sample_backlog.size() != 0) begin
            s = sample_backlog.pop_front();
            req_accel_x <= s[CH_ACCEL_X];
            req_accel_y <= s[CH_ACCEL_X + 1];
            req_accel_z <= s[CH_ACCEL_Z];
            req_temperature <= s[CH_TEMPERATURE];
            req_gyro_x <= s[CH_GYRO_X];
            req_gyro_y <= s[CH_GYRO_X + 1];
            req_gyro_z <= s[CH_GYRO_Z];
            req_valid <= 1'b1;
            if (!idle_off && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 17);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver.
   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         stall_left <= 150;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (!idle_off && $urandom_range(0, 11) == 0) begin
         stall_left <= $urandom_range(0, 16);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic [15:0] clip16(input int v);
      if (v > 32767) return 16'h7FFF;
      if (v < -32768) return 16'h8000;
      return v[15:0];
   endfunction

   function automatic void push_sample(input sample_set_type s);
      sample_backlog.push_back(s);
      samples_queued++;
   endfunction

   function automatic int span_for(input int lim);
      if (lim == 0 || lim >= 8000) return $urandom_range(1, 600);
      return lim * $urandom_range(10, 90) / 100 + 1;
   endfunction

   // Calm stretches around a base level, short bursts of motion and some noise.
   function automatic void queue_motion_story(input int count);
      sample_set_type s;
      int             seg_left;
      int             amp;
      logic           moving;
      seg_left = 0;
      moving = 1'b0;
      for (int n = 0; n < count; n++) begin
         if (seg_left == 0) begin
            moving = ($urandom_range(0, 3) == 0);
            seg_left = moving ? $urandom_range(1, 18) : $urandom_range(5, 90);
         end
         seg_left--;
         if ($urandom_range(0, 19) == 0) begin
            s = ROW_W'({$urandom, $urandom, $urandom, $urandom});
         end else begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
               amp = (ch >= CH_GYRO_X) ? gyro_span : accel_span;
               if (moving) amp = amp * 4 + 1;
               s[ch] = clip16(base_level[ch] + int'($urandom_range(0, 2 * amp)) - amp);
            end
         end
         push_sample(s);
      end
   endfunction

   task automatic settle();
      do @(negedge clock);
      while (samples_accepted != samples_queued || pending_reports.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_setting(input logic [CSR_INDEX_W-1:0] idx, input int val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val[CSR_DATA_W-1:0];
      @(negedge clock);
   endtask

   task automatic load_settings(input int acc, input int gyr, input int need, input int clr);
      write_setting(CSR_ACCEL_LIMIT, acc);
      write_setting(CSR_GYRO_LIMIT, gyr);
      write_setting(CSR_STILL_NEEDED, need);
      write_setting(CSR_MOTION_RESET, clr);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int acc;
      int gyr;
      int need;
      int clr;
      int pick;
      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      @(posedge clock);
      push_sample({CHANNELS{16'h0000}});
      push_sample({CHANNELS{16'h7FFF}});
      push_sample({CHANNELS{16'h8000}});
      push_sample({CHANNELS{16'hFFFF}});
      push_sample({CHANNELS{16'h5555}});
      push_sample({CHANNELS{16'hAAAA}});
      push_sample({16'h8000, 16'h8000, 16'h8000, 16'h1234, 16'h7FFF, 16'h7FFF, 16'h7FFF});
      push_sample({CHANNELS{16'h0001}});
      settle();

      // Zero limits, zero still count needed and zero motion count: always still, every
      // moving sample clears the counters.
      load_settings(0, 0, 0, 0);
      for (int n = 0; n < 3; n++)
         push_sample(ROW_W'({$urandom, $urandom, $urandom, $urandom}));
      settle();

      load_settings(65535, 65535, 4, 15);
      for (int n = 0; n < 6; n++) push_sample({CHANNELS{16'h0000}});
      settle();

      // Lowered requirement clamps the count; moving beats keep the flag until cleared.
      load_settings(0, 65535, 2, 15);
      for (int n = 0; n < 4; n++) push_sample({CHANNELS{16'h0010}});
      settle();

      for (int ch = 0; ch < CHANNELS; ch++) base_level[ch] = int'($urandom_range(0, 2000)) - 1000;
      for (int ph = 0; ph < 12; ph++) begin
         pick = $urandom_range(0, 9);
         acc = (pick == 0) ? 0 : (pick == 1) ? 65535 : $urandom_range(150, 3000);
         pick = $urandom_range(0, 9);
         gyr = (pick == 0) ? 0 : (pick == 1) ? 65535 : $urandom_range(60, 1500);
         pick = $urandom_range(0, 9);
         need = (pick == 0) ? 1023 : (pick == 1) ? 0 : (pick == 2) ? 1 : $urandom_range(1, 60);
         clr = $urandom_range(0, 15);
         if (ph == 0) begin
            need = 1023;
            clr = 15;
         end
         load_settings(acc, gyr, need, clr);
         accel_span = span_for(acc);
         gyro_span = span_for(gyr);
         if (ph % 4 == 3)
            for (int ch = 0; ch < CHANNELS; ch++)
               base_level[ch] = ($urandom_range(0, 5) == 0) ?
                  ($urandom_range(0, 1) ? 32000 : -32000) : int'($urandom_range(0, 6000)) - 3000;
         if (ph == 3 || ph == 8) hold_requests <= hold_requests + 1;
         if (ph >= 10) idle_off <= 1'b1;
         queue_motion_story($urandom_range(85, 100));
         settle();
      end

      repeat (8) @(negedge clock);
      if (mismatches == 0 && pending_reports.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
